// ===== hw/rtl/imuta_pkg.sv =====
`default_nettype none
package imuta_pkg;

  localparam int TIME_W            = 48;
  localparam int VEC_W             = 32;
  localparam int QUEUE_DEPTH_DEF   = 16;

  localparam logic OP_ACCEL = 1'b0;
  localparam logic OP_GYRO  = 1'b1;

  // one queue entry: timestamp and three axes
  typedef struct packed {
    logic [TIME_W-1:0]       t;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } entry_t;

  // request to the interpolation unit: g1 + round((g0 - g1) * w / d)
  typedef struct packed {
    logic signed [VEC_W-1:0] g0;
    logic signed [VEC_W-1:0] g1;
    logic [TIME_W-1:0]       w;
    logic [TIME_W-1:0]       d;
  } interp_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/imuta_ram.sv =====
`default_nettype none
module imuta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/imuta_interp.sv =====
`default_nettype none
module imuta_interp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire imuta_pkg::interp_req_t    req,
  output logic                           done,
  output logic signed [imuta_pkg::VEC_W-1:0] res
);

  localparam int MW = imuta_pkg::VEC_W + 1;          // magnitude of difference
  localparam int TW = imuta_pkg::TIME_W;
  localparam int HW = TW / 2;
  localparam int PW = MW + TW;                        // full product
  localparam int PPW = MW + HW;                       // one partial product

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL0 = 3'd1;
  localparam logic [2:0] U_MUL1 = 3'd2;
  localparam logic [2:0] U_DINI = 3'd3;
  localparam logic [2:0] U_DIV  = 3'd4;
  localparam logic [2:0] U_RND  = 3'd5;
  localparam logic [2:0] U_DONE = 3'd6;

  logic [2:0]   state_r;
  logic [MW-1:0] mag_r;
  logic [TW-1:0] w_r, d_r;
  logic          neg_r;
  logic signed [imuta_pkg::VEC_W-1:0] g1_r;
  logic [PW-1:0] prod_r;
  logic [TW-1:0] rem_r;
  logic [MW-1:0] sh_r;
  logic [5:0]    cnt_r;
  logic signed [imuta_pkg::VEC_W-1:0] res_r;

  logic signed [MW-1:0] diff;
  logic [PPW-1:0] pp;
  logic [TW:0]    trial;
  logic [TW:0]    rem2;
  logic [MW:0]    q_rnd;
  logic signed [MW+1:0] sum;

  always_comb begin
    diff = MW'(req.g0) - MW'(req.g1);
    pp   = PPW'(mag_r) * PPW'((state_r == U_MUL0) ? w_r[HW-1:0] : w_r[TW-1:HW]);
    trial = {rem_r, sh_r[MW-1]};
    rem2  = {rem_r, 1'b0};
    q_rnd = {1'b0, sh_r} + ((rem2 >= {1'b0, d_r}) ? (MW+1)'(1) : (MW+1)'(0));
    sum   = neg_r ? ((MW+2)'(g1_r) - (MW+2)'(q_rnd)) : ((MW+2)'(g1_r) + (MW+2)'(q_rnd));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      case (state_r)
        U_IDLE: begin
          if (start) begin
            g1_r  <= req.g1;
            w_r   <= req.w;
            d_r   <= req.d;
            neg_r <= diff[MW-1];
            mag_r <= diff[MW-1] ? MW'(-diff) : MW'(diff);
            if (req.d == '0) begin
              res_r   <= req.g1;
              state_r <= U_DONE;
            end else begin
              state_r <= U_MUL0;
            end
          end
        end
        U_MUL0: begin
          prod_r  <= PW'(pp);
          state_r <= U_MUL1;
        end
        U_MUL1: begin
          prod_r  <= prod_r + (PW'(pp) << HW);
          state_r <= U_DINI;
        end
        U_DINI: begin
          // upper bits are below d since w <= d
          rem_r   <= prod_r[PW-1:MW];
          sh_r    <= prod_r[MW-1:0];
          cnt_r   <= 6'(MW);
          state_r <= U_DIV;
        end
        U_DIV: begin
          if (trial >= {1'b0, d_r}) begin
            rem_r <= TW'(trial - {1'b0, d_r});
            sh_r  <= {sh_r[MW-2:0], 1'b1};
          end else begin
            rem_r <= trial[TW-1:0];
            sh_r  <= {sh_r[MW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= U_RND;
          end
        end
        U_RND: begin
          if (sum > (MW+2)'(signed'(32'sh7fffffff))) begin
            res_r <= 32'sh7fffffff;
          end else if (sum < (MW+2)'(signed'(-32'sh80000000))) begin
            res_r <= -32'sh80000000;
          end else begin
            res_r <= sum[imuta_pkg::VEC_W-1:0];
          end
          state_r <= U_DONE;
        end
        U_DONE: begin
          state_r <= U_IDLE;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign done = (state_r == U_DONE);
  assign res  = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/imu_accel_gyro_time_align.sv =====
`default_nettype none
// channel | dir | handshake             | payload
// in_     | in  | in_valid / in_stall   | op, sample_time, axis_x/y/z
// out_    | out | out_valid / out_stall | sync_time, accel_x/y/z, gyro_x/y/z
//
// Each queue entry scanned is read through the registered RAM port, and
// the three axes run one after another on the shared interpolation unit,
// which returns g1 without dividing when the gyro interval is zero.
// rst_n clears heads, counts and control; queue RAMs hold no reset value.
// in_stall is high from acceptance until the item is fully processed; a
// result waiting on out_stall holds the block before the queue clean-up.
module imu_accel_gyro_time_align #(
  parameter int QUEUE_DEPTH = imuta_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [47:0] in_sample_time,
  input  wire logic signed [31:0] in_axis_x,
  input  wire logic signed [31:0] in_axis_y,
  input  wire logic signed [31:0] in_axis_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      out_sync_time,
  output logic signed [31:0] out_accel_x,
  output logic signed [31:0] out_accel_y,
  output logic signed [31:0] out_accel_z,
  output logic signed [31:0] out_gyro_x,
  output logic signed [31:0] out_gyro_y,
  output logic signed [31:0] out_gyro_z
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(imuta_pkg::entry_t);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK0 = 4'd1;
  localparam logic [3:0] S_CHK1 = 4'd2;
  localparam logic [3:0] S_CHK2 = 4'd3;
  localparam logic [3:0] S_DRP  = 4'd4;
  localparam logic [3:0] S_DRPC = 4'd5;
  localparam logic [3:0] S_SRC  = 4'd6;
  localparam logic [3:0] S_SRCC = 4'd7;
  localparam logic [3:0] S_INT  = 4'd8;
  localparam logic [3:0] S_INTW = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_PG   = 4'd11;
  localparam logic [3:0] S_PGC  = 4'd12;
  localparam logic [3:0] S_PA   = 4'd13;
  localparam logic [3:0] S_PAC  = 4'd14;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // ring index: (h + i) mod depth, with h + i below twice the depth
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] ahead_r, ahead_nxt, ghead_r, ghead_nxt;
  logic [CW-1:0] acnt_r, acnt_nxt, gcnt_r, gcnt_nxt;
  logic [CW-1:0] nxt_r;
  logic [1:0]    axis_r;
  logic [47:0]   alast_t_r, ts_r;
  imuta_pkg::entry_t g0_r, g1_r, acc_r;
  logic signed [31:0] gx_r, gy_r, gz_r;
  logic          out_valid_r;

  logic          in_acc, a_pop, g_pop, a_we, g_we;
  logic [IW-1:0] a_waddr, g_waddr, a_raddr, g_raddr;
  logic [EW-1:0] a_rbits, g_rbits;
  imuta_pkg::entry_t a_rd, g_rd, in_ent;
  imuta_pkg::interp_req_t req;
  logic          u_start, u_done;
  logic signed [31:0] u_res;
  logic          out_load;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign a_rd     = imuta_pkg::entry_t'(a_rbits);
  assign g_rd     = imuta_pkg::entry_t'(g_rbits);

  always_comb begin
    in_ent.t = in_sample_time;
    in_ent.x = in_axis_x;
    in_ent.y = in_axis_y;
    in_ent.z = in_axis_z;
  end

  imuta_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_aram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(in_ent),
    .raddr(a_raddr), .rdata(a_rbits)
  );

  imuta_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_gram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(in_ent),
    .raddr(g_raddr), .rdata(g_rbits)
  );

  always_comb begin
    req.w = g1_r.t - ts_r;
    req.d = g1_r.t - g0_r.t;
    case (axis_r)
      AX_X:    begin req.g0 = g0_r.x; req.g1 = g1_r.x; end
      AX_Y:    begin req.g0 = g0_r.y; req.g1 = g1_r.y; end
      default: begin req.g0 = g0_r.z; req.g1 = g1_r.z; end
    endcase
  end

  assign u_start = (state_r == S_INT);

  imuta_interp u_interp (
    .clk(clk), .rst_n(rst_n), .start(u_start), .req(req), .done(u_done), .res(u_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    a_we = 1'b0;
    g_we = 1'b0;
    a_waddr = slot(ahead_r, acnt_r);
    g_waddr = slot(ghead_r, gcnt_r);
    a_raddr = ahead_r;
    g_raddr = ghead_r;
    a_pop = 1'b0;
    g_pop = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // a full queue overwrites its oldest entry
          if (in_op == imuta_pkg::OP_ACCEL) begin
            a_we = 1'b1;
            if (acnt_r == CW'(QUEUE_DEPTH)) begin
              a_waddr = ahead_r;
            end
          end else begin
            g_we = 1'b1;
            if (gcnt_r == CW'(QUEUE_DEPTH)) begin
              g_waddr = ghead_r;
            end
          end
          state_nxt = S_CHK0;
        end
      end
      S_CHK0: begin
        a_raddr = slot(ahead_r, acnt_r - CW'(1));
        if (acnt_r == '0 || gcnt_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CHK1;
        end
      end
      S_CHK1: begin
        g_raddr = slot(ghead_r, gcnt_r - CW'(1));
        state_nxt = S_CHK2;
      end
      S_CHK2: begin
        // gyro must start before newest accel and reach oldest accel
        if (g0_r.t < alast_t_r && g_rd.t >= a_rd.t) begin
          state_nxt = S_DRP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DRP: begin
        state_nxt = S_DRPC;
      end
      S_DRPC: begin
        if (a_rd.t < g0_r.t) begin
          a_pop = 1'b1;
          state_nxt = (acnt_r == CW'(1)) ? S_IDLE : S_DRP;
        end else begin
          state_nxt = S_SRC;
        end
      end
      S_SRC: begin
        g_raddr = slot(ghead_r, nxt_r);
        state_nxt = (nxt_r >= gcnt_r) ? S_IDLE : S_SRCC;
      end
      S_SRCC: begin
        state_nxt = (g_rd.t < ts_r) ? S_SRC : S_INT;
      end
      S_INT: begin
        state_nxt = S_INTW;
      end
      S_INTW: begin
        if (u_done) begin
          state_nxt = (axis_r == AX_Z) ? S_OUT : S_INT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          state_nxt = S_PG;
        end
      end
      S_PG: begin
        state_nxt = (gcnt_r == '0) ? S_PA : S_PGC;
      end
      S_PGC: begin
        if (g_rd.t <= ts_r) begin
          g_pop = 1'b1;
          state_nxt = S_PG;
        end else begin
          state_nxt = S_PA;
        end
      end
      S_PA: begin
        state_nxt = (acnt_r == '0) ? S_IDLE : S_PAC;
      end
      S_PAC: begin
        if (a_rd.t <= ts_r) begin
          a_pop = 1'b1;
          state_nxt = S_PA;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // head and count update: push, push over full, or pop
  always_comb begin
    ahead_nxt = ahead_r;
    acnt_nxt  = acnt_r;
    ghead_nxt = ghead_r;
    gcnt_nxt  = gcnt_r;
    if (a_we) begin
      if (acnt_r == CW'(QUEUE_DEPTH)) begin
        ahead_nxt = slot(ahead_r, CW'(1));
      end else begin
        acnt_nxt = acnt_r + CW'(1);
      end
    end else if (a_pop) begin
      ahead_nxt = slot(ahead_r, CW'(1));
      acnt_nxt  = acnt_r - CW'(1);
    end
    if (g_we) begin
      if (gcnt_r == CW'(QUEUE_DEPTH)) begin
        ghead_nxt = slot(ghead_r, CW'(1));
      end else begin
        gcnt_nxt = gcnt_r + CW'(1);
      end
    end else if (g_pop) begin
      ghead_nxt = slot(ghead_r, CW'(1));
      gcnt_nxt  = gcnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ahead_r     <= '0;
      acnt_r      <= '0;
      ghead_r     <= '0;
      gcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ahead_r <= ahead_nxt;
      acnt_r  <= acnt_nxt;
      ghead_r <= ghead_nxt;
      gcnt_r  <= gcnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_CHK1: begin
        g0_r      <= g_rd;
        alast_t_r <= a_rd.t;
      end
      S_DRPC: begin
        ts_r  <= a_rd.t;
        acc_r <= a_rd;
        nxt_r <= CW'(1);
      end
      S_SRCC: begin
        if (g_rd.t < ts_r) begin
          g0_r  <= g_rd;
          nxt_r <= nxt_r + CW'(1);
        end else begin
          g1_r   <= g_rd;
          axis_r <= AX_X;
        end
      end
      S_INTW: begin
        if (u_done) begin
          case (axis_r)
            AX_X:    gx_r <= u_res;
            AX_Y:    gy_r <= u_res;
            default: gz_r <= u_res;
          endcase
          axis_r <= axis_r + 2'd1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_sync_time <= ts_r;
      out_accel_x   <= acc_r.x;
      out_accel_y   <= acc_r.y;
      out_accel_z   <= acc_r.z;
      out_gyro_x    <= gx_r;
      out_gyro_y    <= gy_r;
      out_gyro_z    <= gz_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
